// ===== src/glp_pkg.sv =====
// ----------------------------------------------------------------------------
// glp_pkg: shared types and constants for the glyph locate and scale unit
// Request classes, back-end states, queue entry and configuration bundle.
// ----------------------------------------------------------------------------
package glp_pkg;

  localparam int MAX_GROUPS_DEF = 256;

  localparam int HEIGHT_W = 12;
  localparam int CWIDTH_W = 8;
  localparam int GCOUNT_W = 9;
  localparam int CODE_W   = 21;
  localparam int SCODE_W  = 16;
  localparam int EIDX_W   = 8;
  localparam int ROW_W    = 28;
  localparam int WID_W    = 20;
  localparam int GIDX_W   = 18;
  localparam int NUM_W    = 21;
  localparam int ENTRY_W  = 3 * SCODE_W;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CODE_W-1:0] ASCII_LO  = CODE_W'(32'h20);
  localparam logic [CODE_W-1:0] ASCII_HI  = CODE_W'(32'h7e);
  localparam logic [CODE_W-1:0] CODE_MAX  = CODE_W'(32'hffff);
  localparam logic [GIDX_W-1:0] ASCII_CNT = GIDX_W'(95);
  localparam logic [WID_W-1:0]  WID_ALL   = '1;

  localparam logic [CFG_ADDR_W-1:0] REG_BEST_HEIGHT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHAR_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GROUP_COUNT = 2'd2;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    CLS_WRITE,
    CLS_ASCII,
    CLS_SEARCH,
    CLS_MISS
  } cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_RDWAIT,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    cls_t                cls;
    logic [SCODE_W-1:0]  code;
    logic [HEIGHT_W-1:0] height;
    logic [EIDX_W-1:0]   idx;
    logic [SCODE_W-1:0]  min_code;
    logic [SCODE_W-1:0]  max_code;
    logic [SCODE_W-1:0]  offset;
  } item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] best_height;
    logic [CWIDTH_W-1:0] char_width;
    logic [GCOUNT_W-1:0] group_count;
  } cfg_t;

endpackage

// ===== src/glp_ram.sv =====
// ----------------------------------------------------------------------------
// glp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module glp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/glp_front.sv =====
// ----------------------------------------------------------------------------
// glp_front: input stage and request queue
// Accepts beats, classifies each request, holds up to two in a queue.
// ----------------------------------------------------------------------------
module glp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [glp_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  output logic                            q_valid,
  output glp_pkg::item_t                  q_item,
  input  logic                            q_pop
);

  glp_pkg::item_t q [2];
  glp_pkg::item_t in_item;
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic [glp_pkg::CODE_W-1:0] code;

  assign code = s_tdata[20:0];

  always_comb begin
    in_item.code     = code[glp_pkg::SCODE_W-1:0];
    in_item.height   = s_tdata[32:21];
    in_item.idx      = s_tdata[40:33];
    in_item.min_code = s_tdata[56:41];
    in_item.max_code = s_tdata[72:57];
    in_item.offset   = s_tdata[88:73];
    priority if (s_tuser == glp_pkg::REQ_WRITE) begin
      in_item.cls = glp_pkg::CLS_WRITE;
    end else if (code > glp_pkg::CODE_MAX) begin
      in_item.cls = glp_pkg::CLS_MISS;
    end else if (code >= glp_pkg::ASCII_LO && code <= glp_pkg::ASCII_HI) begin
      in_item.cls = glp_pkg::CLS_ASCII;
    end else begin
      in_item.cls = glp_pkg::CLS_SEARCH;
    end
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== src/glp_back.sv =====
// ----------------------------------------------------------------------------
// glp_back: group search, row multiply and width divide
// Sequencer over the group RAM, one multiply step, bit-serial divider,
// and the result register.
// ----------------------------------------------------------------------------
module glp_back #(
  parameter int MAX_GROUPS = glp_pkg::MAX_GROUPS_DEF,
  localparam int IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
  localparam int CNT_W = $clog2(MAX_GROUPS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  glp_pkg::cfg_t                    cfg,
  input  logic                             q_valid,
  input  glp_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [glp_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                             m_tuser
);

  glp_pkg::state_t state, state_next;
  glp_pkg::item_t  cur;

  logic [CNT_W-1:0] lo, hi, mid;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] count_lim;
  logic [glp_pkg::ENTRY_W-1:0] rdata;
  logic [glp_pkg::SCODE_W-1:0] r_min, r_max, r_off;
  logic             ram_we;
  logic [glp_pkg::GIDX_W-1:0] gidx;
  logic [glp_pkg::ROW_W-1:0]  row;
  logic [glp_pkg::NUM_W-1:0]  num, quo;
  logic [glp_pkg::HEIGHT_W:0] rem, rem_sh;
  logic [4:0]                 div_cnt;
  logic                       fin_direct;
  logic                       out_found;
  logic [glp_pkg::ROW_W-1:0]  out_row;
  logic [glp_pkg::WID_W-1:0]  out_wid;
  logic [glp_pkg::WID_W-1:0]  wid_raw;

  assign {r_min, r_max, r_off} = rdata;
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[CNT_W:1];
  assign count_lim = (32'(cfg.group_count) > MAX_GROUPS) ? CNT_W'(MAX_GROUPS)
                                                          : CNT_W'(cfg.group_count);
  assign ram_we    = q_pop && q_item.cls == glp_pkg::CLS_WRITE &&
                     32'(q_item.idx) < MAX_GROUPS;
  assign rem_sh    = {rem[glp_pkg::HEIGHT_W-1:0], num[glp_pkg::NUM_W-1]};
  assign wid_raw   = quo[glp_pkg::WID_W-1:0];

  glp_ram #(.WIDTH(glp_pkg::ENTRY_W), .DEPTH(MAX_GROUPS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(q_item.idx)),
    .wdata ({q_item.min_code, q_item.max_code, q_item.offset}),
    .raddr (mid[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= glp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    fin_direct = 1'b0;
    unique case (state)
      glp_pkg::ST_IDLE: begin
        if (q_valid && !m_tvalid) begin
          q_pop = 1'b1;
          unique case (q_item.cls)
            glp_pkg::CLS_ASCII:  state_next = glp_pkg::ST_MUL;
            glp_pkg::CLS_SEARCH: state_next = glp_pkg::ST_PROBE;
            default:             fin_direct = 1'b1;
          endcase
        end
      end
      glp_pkg::ST_PROBE: begin
        if (lo >= hi) begin
          fin_direct = 1'b1;
          state_next = glp_pkg::ST_IDLE;
        end else begin
          state_next = glp_pkg::ST_RDWAIT;
        end
      end
      glp_pkg::ST_RDWAIT: begin
        if (cur.code >= r_min && cur.code <= r_max) state_next = glp_pkg::ST_MUL;
        else                                        state_next = glp_pkg::ST_PROBE;
      end
      glp_pkg::ST_MUL: begin
        if (cur.height != cfg.best_height && cfg.best_height != '0) begin
          state_next = glp_pkg::ST_DIV;
        end else begin
          state_next = glp_pkg::ST_FIN;
        end
      end
      glp_pkg::ST_DIV: begin
        if (div_cnt == 5'(glp_pkg::NUM_W - 1)) state_next = glp_pkg::ST_FIN;
      end
      glp_pkg::ST_FIN:  state_next = glp_pkg::ST_IDLE;
      default:          state_next = glp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur  <= q_item;
      lo   <= '0;
      hi   <= count_lim;
      gidx <= glp_pkg::GIDX_W'(q_item.code) - glp_pkg::GIDX_W'(glp_pkg::ASCII_LO);
    end
    if (state == glp_pkg::ST_RDWAIT) begin
      if (cur.code < r_min) begin
        hi <= mid;
      end else if (cur.code > r_max) begin
        lo <= mid + CNT_W'(1);
      end else begin
        gidx <= glp_pkg::GIDX_W'(r_off) + glp_pkg::ASCII_CNT +
                glp_pkg::GIDX_W'(cur.code) - glp_pkg::GIDX_W'(r_min);
      end
    end
    if (state == glp_pkg::ST_MUL) begin
      row     <= glp_pkg::ROW_W'(gidx * cfg.best_height);
      num     <= glp_pkg::NUM_W'(cur.height * cfg.char_width) +
                 glp_pkg::NUM_W'(cfg.best_height >> 1);
      rem     <= '0;
      div_cnt <= '0;
      if (cur.height == cfg.best_height) begin
        quo <= glp_pkg::NUM_W'(cfg.char_width);
      end else if (cfg.best_height == '0) begin
        quo <= glp_pkg::NUM_W'(glp_pkg::WID_ALL);
      end
    end
    if (state == glp_pkg::ST_DIV) begin
      div_cnt <= div_cnt + 5'd1;
      num     <= {num[glp_pkg::NUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, cfg.best_height}) begin
        rem <= rem_sh - {1'b0, cfg.best_height};
        quo <= {quo[glp_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[glp_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_direct || state == glp_pkg::ST_FIN) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_direct) begin
      out_found <= 1'b0;
      out_row   <= '0;
      out_wid   <= '0;
    end else if (state == glp_pkg::ST_FIN) begin
      out_found <= 1'b1;
      out_row   <= row;
      out_wid   <= (wid_raw == '0) ? glp_pkg::WID_W'(1) : wid_raw;
    end
  end

  assign m_tuser = out_found;
  assign m_tdata = {out_wid, out_row};

  a_found_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_found |-> out_wid != '0)
    else $error("found glyph with zero width");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_found |-> out_row == '0 && out_wid == '0)
    else $error("miss result not cleared");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    state == glp_pkg::ST_RDWAIT |-> mid < hi && lo <= mid)
    else $error("probe outside search window");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == glp_pkg::ST_IDLE && !m_tvalid)
    else $error("queue popped while busy");

endmodule

// ===== src/glyph_locate_and_scale.sv =====
// ----------------------------------------------------------------------------
// glyph_locate_and_scale: bitmap font glyph address and width unit
//
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | s_tuser req_type, s_tdata item fields
//  m       | out | m_tvalid/m_tready  | m_tuser found, m_tdata row, width
//  cfg     | in  | cfg_we             | cfg_addr, cfg_data
//
// One item at a time in the back end. Write, miss: direct result. ASCII:
// multiply, then the 21-step serial divider; search adds up to 9 probes.
// Heights equal to best height, or a zero best height, skip the divider.
// Two-entry queue lets the input side accept while a result waits.
// Reset is synchronous; the group table holds no reset value.
// ----------------------------------------------------------------------------
module glyph_locate_and_scale #(
  parameter int MAX_GROUPS = glp_pkg::MAX_GROUPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // code_point, requested_height, entry_index, entry_min_code,
  // entry_max_code, entry_glyph_offset, zero fill
  input  logic [glp_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // glyph_row, glyph_width
  output logic [glp_pkg::OUT_DATA_W-1:0]   m_tdata,
  // found
  output logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic [glp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [glp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  glp_pkg::cfg_t  cfg;
  glp_pkg::item_t q_item;
  logic           q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.best_height <= glp_pkg::HEIGHT_W'(16);
      cfg.char_width  <= glp_pkg::CWIDTH_W'(8);
      cfg.group_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        glp_pkg::REG_BEST_HEIGHT: cfg.best_height <= cfg_data;
        glp_pkg::REG_CHAR_WIDTH:  cfg.char_width  <= cfg_data[glp_pkg::CWIDTH_W-1:0];
        glp_pkg::REG_GROUP_COUNT: cfg.group_count <= cfg_data[glp_pkg::GCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  glp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  glp_back #(.MAX_GROUPS(MAX_GROUPS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: glyph locate and scale testbench
// Drives table writes and glyph lookups through the input stream under
// several register settings. Predicts found, row and width per beat and
// compares them in order against the output stream. Both sides idle in bursts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic        req;
    logic [95:0] data;
  } beat_t;

  typedef struct {
    logic        found;
    logic [27:0] row;
    logic [19:0] width;
  } glyph_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [glp_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [glp_pkg::OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [glp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [glp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  beat_t  pending[$];
  glyph_t expected[$];
  int     errors = 0;
  int     wdog = 0;
  int     src_gap = 0;
  int     snk_gap = 0;
  bit     calm = 0;
  bit     in_flight = 0;
  bit     accepted = 0;

  logic [15:0] tbl_min[256];
  logic [15:0] tbl_max[256];
  logic [15:0] tbl_off[256];
  logic [11:0] m_best_height;
  logic [7:0]  m_char_width;
  logic [8:0]  m_group_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  glyph_locate_and_scale dut (.*);

  function automatic glyph_t locate(logic req, logic [95:0] d);
    glyph_t g;
    logic [20:0] code;
    logic [11:0] height;
    logic [7:0] idx;
    int lo, hi, mid;
    bit hit;
    logic [31:0] gidx, w;
    g = '{1'b0, 28'd0, 20'd0};
    code = d[20:0];
    height = d[32:21];
    idx = d[40:33];
    hit = 0;
    gidx = 0;
    if (req == glp_pkg::REQ_WRITE) begin
      tbl_min[idx] = d[56:41];
      tbl_max[idx] = d[72:57];
      tbl_off[idx] = d[88:73];
      return g;
    end
    if (code > glp_pkg::CODE_MAX) return g;
    if (code >= glp_pkg::ASCII_LO && code <= glp_pkg::ASCII_HI) begin
      gidx = code - 32'h20;
      hit = 1;
    end else begin
      lo = 0;
      hi = (m_group_count > 256) ? 256 : m_group_count;
      while (lo < hi && !hit) begin
        mid = (lo + hi) >> 1;
        if (code < tbl_min[mid]) hi = mid;
        else if (code > tbl_max[mid]) lo = mid + 1;
        else begin
          hit = 1;
          gidx = 32'(tbl_off[mid]) + 95 + 32'(code) - 32'(tbl_min[mid]);
        end
      end
    end
    if (!hit) return g;
    if (height == m_best_height) w = m_char_width;
    else if (m_best_height == 0) w = 32'hFFFFF;
    else w = (32'(height) * m_char_width + (m_best_height >> 1)) / m_best_height;
    if (w == 0) w = 1;
    g.found = 1'b1;
    g.row = 28'(gidx * m_best_height);
    g.width = w[19:0];
    return g;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin : drv
    beat_t b;
    if (!rst) begin
      if (accepted) begin
        accepted = 0;
        in_flight = 0;
      end
      if (!in_flight) begin
        if (src_gap > 0) src_gap--;
        else if (pending.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(0, 4);
          else begin
            b = pending.pop_front();
            s_tdata <= b.data;
            s_tuser <= b.req;
            in_flight = 1;
          end
        end
      end
      s_tvalid <= in_flight;
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      wdog++;
      if (s_tvalid && s_tready) begin
        expected.push_back(locate(s_tuser, s_tdata));
        accepted = 1;
        wdog = 0;
      end
      if (m_tvalid && m_tready) begin
        wdog = 0;
        if (expected.size() == 0) begin
          report("unexpected beat", 32'(m_tdata[27:0]), 32'd0);
        end else begin
          glyph_t e;
          e = expected.pop_front();
          if (m_tuser !== e.found) report("found", 32'(m_tuser), 32'(e.found));
          if (m_tdata[27:0] !== e.row) report("row", 32'(m_tdata[27:0]), 32'(e.row));
          if (m_tdata[47:28] !== e.width)
            report("width", 32'(m_tdata[47:28]), 32'(e.width));
        end
      end
      if (wdog >= WDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [95:0] pack(logic [20:0] code, logic [11:0] h,
                                       logic [7:0] idx, logic [15:0] mn,
                                       logic [15:0] mx, logic [15:0] off);
    return {7'd0, off, mx, mn, idx, h, code};
  endfunction

  task automatic push(logic req, logic [95:0] d);
    beat_t b;
    b.req = req;
    b.data = d;
    pending.push_back(b);
  endtask

  task automatic drain();
    while (pending.size() > 0 || expected.size() > 0 || in_flight) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_reg(logic [glp_pkg::CFG_ADDR_W-1:0] a,
                         logic [glp_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (a)
      glp_pkg::REG_BEST_HEIGHT: m_best_height = v;
      glp_pkg::REG_CHAR_WIDTH: m_char_width = v[7:0];
      default: m_group_count = v[8:0];
    endcase
  endtask

  // sorted groups filling slots 0 to n-1, random spans and offsets
  task automatic load_table(int n);
    int base, span;
    base = 16'h80;
    for (int i = 0; i < n; i++) begin
      span = $urandom_range(0, 200);
      if (i == n - 1) span = 16'hFFFF - base;
      push(glp_pkg::REQ_WRITE, pack(21'($urandom), 12'($urandom), 8'(i), 16'(base),
           16'(base + span), 16'($urandom)));
      base = base + span + 1 + $urandom_range(0, 40);
      if (base > 16'hFF00) base = 16'hFF00;
    end
  endtask

  function automatic logic [20:0] pick_code();
    case ($urandom_range(0, 9))
      0: return 21'($urandom_range(0, 31));
      1, 2: return 21'($urandom_range(32, 126));
      3: return 21'($urandom_range(21'h10000, 21'h10FFFF));
      4: return 21'($urandom);
      default: return 21'($urandom_range(127, 16'hFFFF));
    endcase
  endfunction

  task automatic lookups(int n);
    logic [11:0] h;
    for (int i = 0; i < n; i++) begin
      h = ($urandom_range(0, 3) == 0) ? m_best_height : 12'($urandom);
      if ($urandom_range(0, 15) == 0)
        push(glp_pkg::REQ_WRITE, pack(21'($urandom), 12'($urandom),
                                      8'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom)));
      else push(glp_pkg::REQ_LOOKUP, pack(pick_code(), h, 8'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom)));
    end
  endtask

  initial begin
    m_best_height = 16;
    m_char_width = 8;
    m_group_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: table empty, ASCII bounds, misses, extremes
    push(glp_pkg::REQ_LOOKUP, pack(21'h20, 12'd16, 8'd0, 16'd0, 16'd0, 16'd0));
    push(glp_pkg::REQ_LOOKUP, pack(21'h7E, 12'd0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push(glp_pkg::REQ_LOOKUP, pack(21'h1F, 12'd16, 8'd0, 16'd0, 16'd0, 16'd0));
    push(glp_pkg::REQ_LOOKUP, pack(21'h7F, 12'hFFF, 8'd0, 16'd0, 16'd0, 16'd0));
    push(glp_pkg::REQ_LOOKUP, pack(21'h10000, 12'd5, 8'd0, 16'd0, 16'd0, 16'd0));
    push(glp_pkg::REQ_LOOKUP, pack(21'h1FFFFF, 12'hFFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF));
    push(glp_pkg::REQ_LOOKUP, pack(21'h41, 12'd1, 8'd0, 16'd0, 16'd0, 16'd0));
    load_table(256);
    drain();
    set_reg(glp_pkg::REG_GROUP_COUNT, 12'd256);
    push(glp_pkg::REQ_LOOKUP, pack(21'h80, 12'd16, 8'd0, 16'd0, 16'd0, 16'd0));
    push(glp_pkg::REQ_LOOKUP, pack(21'hFFFF, 12'd24, 8'd0, 16'd0, 16'd0, 16'd0));
    push(glp_pkg::REQ_LOOKUP, pack(21'h0, 12'd16, 8'd0, 16'd0, 16'd0, 16'd0));
    lookups(200);
    drain();
    // count above table size, extreme heights and widths
    set_reg(glp_pkg::REG_GROUP_COUNT, 12'd511);
    set_reg(glp_pkg::REG_BEST_HEIGHT, 12'hFFF);
    set_reg(glp_pkg::REG_CHAR_WIDTH, 12'd255);
    lookups(200);
    drain();
    // zero best height and char width
    set_reg(glp_pkg::REG_BEST_HEIGHT, 12'd0);
    set_reg(glp_pkg::REG_CHAR_WIDTH, 12'd0);
    set_reg(glp_pkg::REG_GROUP_COUNT, 12'd37);
    push(glp_pkg::REQ_LOOKUP, pack(21'h30, 12'd0, 8'd0, 16'd0, 16'd0, 16'd0));
    lookups(150);
    drain();
    // unsorted table from random rewrites, small count
    set_reg(glp_pkg::REG_BEST_HEIGHT, 12'd1);
    set_reg(glp_pkg::REG_CHAR_WIDTH, 12'd1);
    set_reg(glp_pkg::REG_GROUP_COUNT, 12'd1);
    lookups(100);
    drain();
    set_reg(glp_pkg::REG_BEST_HEIGHT, 12'($urandom_range(1, 4095)));
    set_reg(glp_pkg::REG_CHAR_WIDTH, 12'($urandom_range(1, 255)));
    set_reg(glp_pkg::REG_GROUP_COUNT, 12'd200);
    lookups(80);
    calm = 1;
    lookups(200);
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
